[rtl/radius_neighbor_insert_assert.svh]
// assertion macros for the radius neighbour insert block
`ifndef RADIUS_NEIGHBOR_INSERT_ASSERT_SVH
`define RADIUS_NEIGHBOR_INSERT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define RNI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rni assertion failed");

// next-cycle implication under synchronous active-low reset
`define RNI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rni assertion failed");

`endif

[rtl/rni_pkg.sv]
// constants shared by the radius neighbour insert block
package rni_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_W    = 20;
    localparam int RAD_W      = 20;
    localparam int PT_W       = 3 * COORD_W;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int NIDX_W     = 5;
    localparam int NCNT_W     = 6;
    localparam int NB_RES_MAX = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int R2_W       = 2 * RAD_W;
    localparam int S_TDATA_W  = ((PT_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * NIDX_W + NCNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

[rtl/radius_neighbor_insert.sv]
// top level of the radius neighbour insert block
//
// channel   direction  carries
// s_axis    in         tuser mode, tdata point x/y/z
// m_axis    out        tuser is_neighbor, tdata indices/count/full, tlast
// cfg       in         radius register write
//
// an insert over n >= 1 stored points loads its summary once the scan pipeline has drained
// a start or an insert into an empty table skips the scan; input reopens as the summary loads
// the scan reads one table entry per cycle, while m_axis is not stalled, through the single ram read port
// one item at a time: s_axis_tready is high only while no item is in work
// a stalled m_axis freezes the scan pipeline, no result is dropped
// synchronous reset empties the table and sets the radius to 0.5 m
module radius_neighbor_insert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [rni_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // pos_x, pos_y, pos_z
    input  logic                            i_s_axis_tuser,  // mode
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [rni_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // neighbor_index, new_index,
                                                             // neighbor_count, store_full
    output logic                            o_m_axis_tuser,  // is_neighbor
    output logic                            o_m_axis_tlast,  // last
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rni_pkg::RAD_W-1:0]       i_cfg_data
);
    import rni_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]              r_state;
    logic [RAD_W-1:0]        r_radius;
    logic [R2_W-1:0]         r_r2;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_rd_idx;
    logic [NCNT_W-1:0]       r_hits;
    logic [PT_W-1:0]         r_pt;

    logic                    r_v1;
    logic [IDX_W-1:0]        r_i1;
    logic                    r_v2;
    logic [IDX_W-1:0]        r_i2;
    logic [SQ_W-1:0]         r_sq_x;
    logic [SQ_W-1:0]         r_sq_y;
    logic [SQ_W-1:0]         r_sq_z;

    logic                    r_out_valid;
    logic                    r_out_isn;
    logic [NIDX_W-1:0]       r_out_nidx;
    logic [NIDX_W-1:0]       r_out_newi;
    logic [NCNT_W-1:0]       r_out_cnt;
    logic                    r_out_full;

    logic                    w_in_acc;
    logic                    w_adv;
    logic                    w_issue;
    logic                    w_hit;
    logic                    w_ld_nb;
    logic                    w_ld_sum;
    logic                    w_full;
    logic                    w_wr_en;
    logic [PT_W-1:0]         w_rd_data;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [DIFF_W-1:0] w_dz;
    logic [DIFF_W-1:0]       w_ax;
    logic [DIFF_W-1:0]       w_ay;
    logic [DIFF_W-1:0]       w_az;
    logic [D2_W-1:0]         w_d2;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_issue         = (r_state == ST_SCAN) && (r_rd_idx != r_n);
    assign w_full          = (r_n == CNT_W'(MAX_POINTS));
    assign w_ld_sum        = (r_state == ST_SUM) && w_adv;
    assign w_wr_en         = w_ld_sum && !w_full;

    rni_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_n[IDX_W-1:0]),
        .i_wr_data (r_pt),
        .i_rd_en   (w_issue && w_adv),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // per-axis difference and magnitude
    always_comb begin
        w_dx = $signed({r_pt[COORD_W-1], r_pt[COORD_W-1:0]})
             - $signed({w_rd_data[COORD_W-1], w_rd_data[COORD_W-1:0]});
        w_dy = $signed({r_pt[2*COORD_W-1], r_pt[2*COORD_W-1:COORD_W]})
             - $signed({w_rd_data[2*COORD_W-1], w_rd_data[2*COORD_W-1:COORD_W]});
        w_dz = $signed({r_pt[3*COORD_W-1], r_pt[3*COORD_W-1:2*COORD_W]})
             - $signed({w_rd_data[3*COORD_W-1], w_rd_data[3*COORD_W-1:2*COORD_W]});
        w_ax = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
        w_ay = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        w_az = w_dz[DIFF_W-1] ? DIFF_W'(-w_dz) : DIFF_W'(w_dz);
    end

    assign w_d2    = D2_W'(r_sq_x) + D2_W'(r_sq_y) + D2_W'(r_sq_z);
    assign w_hit   = r_v2 && (w_d2 < D2_W'(r_r2));
    assign w_ld_nb = w_adv && w_hit && (r_hits < NCNT_W'(NB_RES_MAX));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radius    <= RAD_W'(32768);
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!w_issue && !r_v1 && !r_v2) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (w_adv) begin
                        r_state <= ST_IDLE;
                        if (!w_full) begin
                            r_count <= r_n + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_adv) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
            end
            if (w_ld_nb || w_ld_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pt     <= i_s_axis_tdata[PT_W-1:0];
            r_r2     <= R2_W'(r_radius) * R2_W'(r_radius);
            r_n      <= i_s_axis_tuser ? r_count : '0;
            r_rd_idx <= '0;
            r_hits   <= '0;
        end
        if (w_adv) begin
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_i1   <= r_rd_idx[IDX_W-1:0];
            r_i2   <= r_i1;
            r_sq_x <= SQ_W'(w_ax) * SQ_W'(w_ax);
            r_sq_y <= SQ_W'(w_ay) * SQ_W'(w_ay);
            r_sq_z <= SQ_W'(w_az) * SQ_W'(w_az);
            if (w_hit) begin
                r_hits <= r_hits + NCNT_W'(1);
            end
        end
        if (w_ld_nb) begin
            r_out_isn  <= 1'b1;
            r_out_nidx <= NIDX_W'(r_i2);
            r_out_newi <= '0;
            r_out_cnt  <= '0;
            r_out_full <= 1'b0;
        end else if (w_ld_sum) begin
            r_out_isn  <= 1'b0;
            r_out_nidx <= '0;
            r_out_newi <= w_full ? '0 : NIDX_W'(r_n);
            r_out_cnt  <= r_hits;
            r_out_full <= w_full;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_isn;
    assign o_m_axis_tlast  = !r_out_isn;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_full, r_out_cnt, r_out_newi, r_out_nidx});

`include "radius_neighbor_insert_assert.svh"

    `RNI_ASSERT_IMP(a_wr_after_scan, i_clk, i_rst_n, w_wr_en, !r_v1 && !r_v2 && !w_issue)
    `RNI_ASSERT_IMP(a_acc_when_drained, i_clk, i_rst_n, w_in_acc, !r_v1 && !r_v2)
    `RNI_ASSERT_NXT(a_sum_ends_item, i_clk, i_rst_n, w_ld_sum, r_state == ST_IDLE)
    `RNI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS))

endmodule

[rtl/rni_ram.sv]
// generic simple dual-port ram with registered read
module rni_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
